// ===== design/sparse_poly_add_merge_assert.svh =====
// assertion macros for the merge unit
`ifndef SPARSE_POLY_ADD_MERGE_ASSERT_SVH
`define SPARSE_POLY_ADD_MERGE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spa_pkg.sv =====
package spa_pkg;

  localparam int COEFF_W = 32;
  localparam int EXPO_W  = 16;
  localparam int SUM_W   = 33;
  localparam int TERM_W  = COEFF_W + EXPO_W;
  localparam int FUNC_W  = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - SUM_W - EXPO_W;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } merge_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } merge_status_t;

endpackage

// ===== design/spa_term_ram.sv =====
module spa_term_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/spa_merge.sv =====
module spa_merge #(
  parameter int CW = 6,
  parameter int IW = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CW-1:0]                 a_cnt,
  input  logic [CW-1:0]                 b_cnt,
  output logic [IW-1:0]                 a_addr,
  output logic [IW-1:0]                 b_addr,
  input  logic [spa_pkg::TERM_W-1:0]    a_rdata,
  input  logic [spa_pkg::TERM_W-1:0]    b_rdata,
  output spa_pkg::merge_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spa_pkg::SUM_W-1:0]     out_coeff,
  output logic [spa_pkg::EXPO_W-1:0]    out_expo,
  output logic                          out_empty,
  output logic                          out_last
);

  spa_pkg::merge_state_t state, state_next;

  logic [CW-1:0] i, j;
  logic          advance, adv_a, adv_b;

  // term held back until it is known whether another follows
  logic                        held_v;
  logic [spa_pkg::SUM_W-1:0]   held_coeff;
  logic [spa_pkg::EXPO_W-1:0]  held_expo;

  logic                        new_v;
  logic [spa_pkg::SUM_W-1:0]   new_coeff;
  logic [spa_pkg::EXPO_W-1:0]  new_expo;

  logic                        push, push_last, push_empty, can_push, hold_load;

  logic [spa_pkg::COEFF_W-1:0] a_c, b_c;
  logic [spa_pkg::EXPO_W-1:0]  a_e, b_e;
  logic                        a_has, b_has;
  logic [spa_pkg::SUM_W-1:0]   sum;

  assign a_c = a_rdata[spa_pkg::COEFF_W-1:0];
  assign a_e = a_rdata[spa_pkg::TERM_W-1:spa_pkg::COEFF_W];
  assign b_c = b_rdata[spa_pkg::COEFF_W-1:0];
  assign b_e = b_rdata[spa_pkg::TERM_W-1:spa_pkg::COEFF_W];
  assign a_has = (i < a_cnt);
  assign b_has = (j < b_cnt);
  assign sum = {a_c[spa_pkg::COEFF_W-1], a_c} + {b_c[spa_pkg::COEFF_W-1], b_c};
  assign a_addr = i[IW-1:0];
  assign b_addr = j[IW-1:0];
  assign can_push = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    advance    = 1'b0;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    new_v      = 1'b0;
    new_coeff  = '0;
    new_expo   = '0;
    push       = 1'b0;
    push_last  = 1'b0;
    push_empty = 1'b0;
    hold_load  = 1'b0;
    status.done = 1'b0;
    status.busy = (state != spa_pkg::ST_IDLE);
    unique case (state)
      spa_pkg::ST_IDLE: begin
        if (start) begin
          state_next = spa_pkg::ST_READ;
        end
      end
      spa_pkg::ST_READ: begin
        if (!a_has && !b_has) begin
          state_next = spa_pkg::ST_FINISH;
        end else begin
          state_next = spa_pkg::ST_CMP;
        end
      end
      spa_pkg::ST_CMP: begin
        if (!b_has || (a_has && a_e > b_e)) begin
          new_v     = 1'b1;
          new_coeff = {a_c[spa_pkg::COEFF_W-1], a_c};
          new_expo  = a_e;
          adv_a     = 1'b1;
        end else if (!a_has || b_e > a_e) begin
          new_v     = 1'b1;
          new_coeff = {b_c[spa_pkg::COEFF_W-1], b_c};
          new_expo  = b_e;
          adv_b     = 1'b1;
        end else begin
          new_v     = (sum != '0);
          new_coeff = sum;
          new_expo  = a_e;
          adv_a     = 1'b1;
          adv_b     = 1'b1;
        end
        // a new term displaces the held one into the output register
        if (!(new_v && held_v && !can_push)) begin
          advance    = 1'b1;
          hold_load  = new_v;
          push       = new_v && held_v;
          state_next = spa_pkg::ST_READ;
        end
      end
      spa_pkg::ST_FINISH: begin
        if (can_push) begin
          push        = 1'b1;
          push_last   = 1'b1;
          push_empty  = !held_v;
          status.done = 1'b1;
          state_next  = spa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i      <= '0;
      j      <= '0;
      held_v <= 1'b0;
    end else if (start && state == spa_pkg::ST_IDLE) begin
      i      <= '0;
      j      <= '0;
      held_v <= 1'b0;
    end else begin
      if (advance && adv_a) begin
        i <= i + 1'b1;
      end
      if (advance && adv_b) begin
        j <= j + 1'b1;
      end
      if (hold_load) begin
        held_v <= 1'b1;
      end else if (status.done) begin
        held_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      held_coeff <= new_coeff;
      held_expo  <= new_expo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_coeff <= push_empty ? '0 : held_coeff;
      out_expo  <= push_empty ? '0 : held_expo;
      out_empty <= push_empty;
      out_last  <= push_last;
    end
  end

`include "sparse_poly_add_merge_assert.svh"

  `SPA_ASSERT_NOW(a_idx_bound, state != spa_pkg::ST_IDLE, i <= a_cnt, "a index past count")
  `SPA_ASSERT_NOW(b_idx_bound, state != spa_pkg::ST_IDLE, j <= b_cnt, "b index past count")
  `SPA_ASSERT_NOW(push_room, push, can_push, "output register overwritten")
  `SPA_ASSERT_NEXT(finish_beat, status.done, out_valid && out_last, "finish gave no last beat")
  `SPA_ASSERT_NOW(empty_zero, out_valid && out_empty,
    out_coeff == '0 && out_expo == '0 && out_last, "empty beat carries a term")

endmodule

// ===== design/sparse_poly_add_merge.sv =====
// channel | beat fields (tdata low bit up)            | side fields
// s_*     | coeff[31:0], expo[47:32]                  | tuser: func
// m_*     | sum_coeff[32:0], sum_expo[48:33], zeros   | tuser: empty_res, tlast: last
//
// a load beat writes its term straight into its store; s_tready stays high between adds
// an add walks both term stores, each merge step a store read and then a compare,
// plus a last read and a finish state that closes the add
// the merge step rate is set by the registered read of the two term stores
// reset clears both term counts and the merge control; the stores keep their contents
// m_tready low stalls the merge only when a finished term has nowhere to go
module sparse_poly_add_merge #(
  parameter int MAX_TERMS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]     s_tdata,   // coeff, expo
  input  logic [spa_pkg::FUNC_W-1:0]        s_tuser,   // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [spa_pkg::OUT_DATA_W-1:0]    m_tdata,   // sum_coeff, sum_expo, padding
  output logic [0:0]                        m_tuser,   // empty_res
  output logic                              m_tlast
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [CW-1:0] a_cnt, b_cnt;
  logic          accept, start, a_we, b_we;
  logic [IW-1:0] a_addr, b_addr;
  logic [spa_pkg::TERM_W-1:0] a_rdata, b_rdata, wterm;
  spa_pkg::merge_status_t status;

  logic [spa_pkg::SUM_W-1:0]  out_coeff;
  logic [spa_pkg::EXPO_W-1:0] out_expo;
  logic                       out_empty;

  // no beat is taken while a merge runs
  assign s_tready = !status.busy;
  assign accept   = s_tvalid && s_tready;
  assign wterm    = s_tdata[spa_pkg::TERM_W-1:0];

  always_comb begin
    start = 1'b0;
    a_we  = 1'b0;
    b_we  = 1'b0;
    unique case (s_tuser)
      spa_pkg::FUNC_LOAD_A: a_we  = accept && (a_cnt < CW'(MAX_TERMS));
      spa_pkg::FUNC_LOAD_B: b_we  = accept && (b_cnt < CW'(MAX_TERMS));
      spa_pkg::FUNC_ADD:    start = accept;
      default: begin
        // unused selector, beat is dropped
      end
    endcase
  end

  // term counts; a full store ignores further loads, the add clears both
  always_ff @(posedge clk) begin
    if (rst || status.done) begin
      a_cnt <= '0;
      b_cnt <= '0;
    end else begin
      if (a_we) begin
        a_cnt <= a_cnt + 1'b1;
      end
      if (b_we) begin
        b_cnt <= b_cnt + 1'b1;
      end
    end
  end

  spa_term_ram #(
    .DEPTH(MAX_TERMS), .AW(IW), .W(spa_pkg::TERM_W)
  ) u_a_store (
    .clk(clk), .we(a_we), .waddr(a_cnt[IW-1:0]), .wdata(wterm),
    .raddr(a_addr), .rdata(a_rdata)
  );

  spa_term_ram #(
    .DEPTH(MAX_TERMS), .AW(IW), .W(spa_pkg::TERM_W)
  ) u_b_store (
    .clk(clk), .we(b_we), .waddr(b_cnt[IW-1:0]), .wdata(wterm),
    .raddr(b_addr), .rdata(b_rdata)
  );

  spa_merge #(
    .CW(CW), .IW(IW)
  ) u_merge (
    .clk(clk), .rst(rst), .start(start),
    .a_cnt(a_cnt), .b_cnt(b_cnt),
    .a_addr(a_addr), .b_addr(b_addr),
    .a_rdata(a_rdata), .b_rdata(b_rdata),
    .status(status),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_coeff(out_coeff), .out_expo(out_expo),
    .out_empty(out_empty), .out_last(m_tlast)
  );

  // result beat packing, coefficient in the low bits
  assign m_tdata = {{spa_pkg::OUT_PAD_W{1'b0}}, out_expo, out_coeff};
  assign m_tuser = out_empty;

endmodule
